// ===== rtl/wwnc_pkg.sv =====
package wwnc_pkg;

	localparam int NUM_WINDOWS = 4;
	localparam int DAYS_IN_WEEK = 7;
	localparam int SECS_PER_MINUTE = 60;
	localparam int SECS_PER_HOUR = 60 * SECS_PER_MINUTE;
	localparam int SECS_PER_DAY = 24 * SECS_PER_HOUR;

	localparam int DOW_W = 3;
	localparam int SEC_W = 17;
	localparam int MASK_W = 7;
	localparam int CHG_W = 18;
	localparam int OFF_W = 4;
	localparam int SUM_W = 21;
	localparam int DIST_W = 20;
	localparam int COUNT_W = 3;
	localparam int ENTRY_W = 41;
	localparam int ADDR_W = 3;

	localparam logic [ADDR_W-1:0] REG_WINDOW_COUNT = 3'd0;
	localparam logic [ADDR_W-1:0] REG_WINDOW_ENTRY_0 = 3'd1;
	localparam logic [ADDR_W-1:0] REG_WINDOW_ENTRY_1 = 3'd2;
	localparam logic [ADDR_W-1:0] REG_WINDOW_ENTRY_2 = 3'd3;
	localparam logic [ADDR_W-1:0] REG_WINDOW_ENTRY_3 = 3'd4;

	typedef struct packed {
		logic [CHG_W-1:0] change;
		logic [OFF_W-1:0] offset;
		logic             in_span;
	} win_s1_t;

	function automatic logic [MASK_W-1:0] day_bit(input logic [DOW_W-1:0] dow);
		logic [MASK_W:0] r;
		r = (MASK_W+1)'(1) << dow;
		return r[MASK_W-1:0];
	endfunction

	function automatic logic [OFF_W-1:0] next_offset(input logic [DOW_W-1:0] dow,
			input logic [MASK_W-1:0] mask);
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] pos;
		off = OFF_W'(DAYS_IN_WEEK + 1);
		for (int i = DAYS_IN_WEEK; i >= 1; i--) begin
			pos = OFF_W'(dow) + OFF_W'(i);
			if (pos >= OFF_W'(2 * DAYS_IN_WEEK)) begin
				pos = pos - OFF_W'(2 * DAYS_IN_WEEK);
			end else if (pos >= OFF_W'(DAYS_IN_WEEK)) begin
				pos = pos - OFF_W'(DAYS_IN_WEEK);
			end
			if (mask[pos[2:0]]) begin
				off = OFF_W'(i);
			end
		end
		return off;
	endfunction

	function automatic logic [SUM_W-1:0] day_seconds(input logic [OFF_W-1:0] off);
		return SUM_W'(off) * SUM_W'(SECS_PER_DAY);
	endfunction

endpackage

// ===== rtl/weekly_window_next_change_core.sv =====
// Weekly window scheduler: next opening or closing time.
// Up to four weekly windows are written over the configuration channel
// (cfg_valid, cfg_ready, cfg_addr, cfg_data): index 0 holds the window count,
// indexes 1 to 4 hold the window entries. cfg_ready is always high; the user
// must make writes only while no query is in flight; the block does not enforce this.
// A query word enters on the s_axis group and its result word leaves on the
// m_axis group. An accepted word passes four register stages on its way to
// m_axis: day offset search, distance per window, pairwise minimum, and final
// minimum in the output register. One word is taken every cycle when the
// receiver keeps up.
// When the receiver stalls, the result waits in the output register and the
// stages behind it keep filling until every stage holds a word; only then
// does s_axis_tready fall. Nothing is lost or repeated.
// An asynchronous reset empties the pipeline and clears every configuration
// register, so the block starts with no windows and reports always open.
module weekly_window_next_change_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [40:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // weekday, seconds_of_day, zero pad
	input  logic        s_axis_tuser,  // seek_opening
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // in_window, has_change, seconds_until_change, zero pad
);

	localparam int NW = wwnc_pkg::NUM_WINDOWS;

	logic [wwnc_pkg::COUNT_W-1:0] window_count_q;
	logic [wwnc_pkg::ENTRY_W-1:0] window_entry_q [NW];
	logic [wwnc_pkg::COUNT_W-1:0] count_sat;

	logic en_s1, en_s2, en_s3, en_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic [wwnc_pkg::DOW_W-1:0] dow;
	logic [wwnc_pkg::SEC_W-1:0] now;
	logic                       seek;

	wwnc_pkg::win_s1_t          win_d [NW];
	wwnc_pkg::win_s1_t          win_s1 [NW];
	logic [NW-1:0]              wvld_d, wvld_s1;
	logic [wwnc_pkg::SEC_W-1:0] now_s1;
	logic                       none_s1;

	logic [wwnc_pkg::DIST_W-1:0] dist_d [NW];
	logic [wwnc_pkg::DIST_W-1:0] dist_s2 [NW];
	logic [NW-1:0]               wvld_s2;
	logic                        inside_d, inside_s2, none_s2;

	logic [wwnc_pkg::DIST_W-1:0] pmin_d [NW/2];
	logic [wwnc_pkg::DIST_W-1:0] pmin_s3 [NW/2];
	logic [NW/2-1:0]             pvld_d, pvld_s3;
	logic                        inside_s3, none_s3;

	logic [wwnc_pkg::DIST_W-1:0] best_d;
	logic [wwnc_pkg::DIST_W-1:0] best_s4;
	logic                        inside_s4, none_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_count_q <= '0;
			for (int k = 0; k < NW; k++) begin
				window_entry_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				wwnc_pkg::REG_WINDOW_COUNT: window_count_q <= cfg_data[wwnc_pkg::COUNT_W-1:0];
				wwnc_pkg::REG_WINDOW_ENTRY_0: window_entry_q[0] <= cfg_data;
				wwnc_pkg::REG_WINDOW_ENTRY_1: window_entry_q[1] <= cfg_data;
				wwnc_pkg::REG_WINDOW_ENTRY_2: window_entry_q[2] <= cfg_data;
				wwnc_pkg::REG_WINDOW_ENTRY_3: window_entry_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign count_sat = (window_count_q > wwnc_pkg::COUNT_W'(NW)) ?
		wwnc_pkg::COUNT_W'(NW) : window_count_q;

	assign en_s4 = !vld_s4 || m_axis_tready;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_axis_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	assign dow = s_axis_tdata[2:0];
	assign now = s_axis_tdata[19:3];
	assign seek = s_axis_tuser;

	always_comb begin
		logic [wwnc_pkg::SEC_W-1:0]  st;
		logic [wwnc_pkg::SEC_W-1:0]  en;
		logic [wwnc_pkg::MASK_W-1:0] mask;
		logic                        today;
		for (int k = 0; k < NW; k++) begin
			st = window_entry_q[k][16:0];
			en = window_entry_q[k][33:17];
			mask = window_entry_q[k][40:34];
			today = |(mask & wwnc_pkg::day_bit(dow));
			win_d[k].change = seek ? wwnc_pkg::CHG_W'(st) :
				wwnc_pkg::CHG_W'(en) + wwnc_pkg::CHG_W'(wwnc_pkg::SECS_PER_MINUTE);
			win_d[k].offset = (today && (wwnc_pkg::CHG_W'(now) < win_d[k].change)) ?
				'0 : wwnc_pkg::next_offset(dow, mask);
			win_d[k].in_span = today && (now >= st) && (now <= en);
			wvld_d[k] = wwnc_pkg::COUNT_W'(k) < count_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			win_s1 <= win_d;
			wvld_s1 <= wvld_d;
			now_s1 <= now;
			none_s1 <= (window_count_q == '0);
		end
	end

	always_comb begin
		logic [wwnc_pkg::SUM_W-1:0] sum;
		logic [wwnc_pkg::SUM_W-1:0] diff;
		inside_d = 1'b0;
		for (int k = 0; k < NW; k++) begin
			sum = wwnc_pkg::SUM_W'(win_s1[k].change) + wwnc_pkg::day_seconds(win_s1[k].offset);
			diff = sum - wwnc_pkg::SUM_W'(now_s1);
			dist_d[k] = (sum < wwnc_pkg::SUM_W'(now_s1)) ? '0 : diff[wwnc_pkg::DIST_W-1:0];
			inside_d = inside_d | (win_s1[k].in_span & wvld_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dist_s2 <= dist_d;
			wvld_s2 <= wvld_s1;
			inside_s2 <= inside_d;
			none_s2 <= none_s1;
		end
	end

	always_comb begin
		for (int p = 0; p < NW / 2; p++) begin
			pmin_d[p] = (wvld_s2[2*p+1] && (dist_s2[2*p+1] < dist_s2[2*p])) ?
				dist_s2[2*p+1] : dist_s2[2*p];
			pvld_d[p] = wvld_s2[2*p];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pmin_s3 <= pmin_d;
			pvld_s3 <= pvld_d;
			inside_s3 <= inside_s2;
			none_s3 <= none_s2;
		end
	end

	assign best_d = (pvld_s3[1] && (pmin_s3[1] < pmin_s3[0])) ? pmin_s3[1] : pmin_s3[0];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			best_s4 <= none_s3 ? '0 : best_d;
			inside_s4 <= none_s3 | inside_s3;
			none_s4 <= none_s3;
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata = {2'b00, best_s4, !none_s4, inside_s4};

	a_no_window_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[0] && (m_axis_tdata[21:2] == '0))
		else $error("result without change time must report open and zero distance");

	a_change_needs_windows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> (window_count_q != '0))
		else $error("change time reported with no windows configured");

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_axis_tready)
		else $error("input held off while the first stage is empty");

endmodule
